@@ design/bbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Shared types, status codes and the byte classifier.
// ----------------------------------------------------------------------------
package bbc_pkg;

   // Verdict codes
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_MISMATCH = 3'd2;
   localparam logic [2:0] ST_OPEN     = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;

   // Bracket kinds
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_ROUND  = 2'd1;
   localparam logic [1:0] KIND_CURLY  = 2'd2;
   localparam logic [1:0] KIND_SQUARE = 2'd3;

   // Bracket characters
   localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
   localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
   localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
   localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;
   localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
   localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;

   // Classified byte, as it travels from front to back
   typedef struct packed {
      logic       last;
      logic       is_open;
      logic       is_close;
      logic [1:0] kind;
   } bbc_item_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } bbc_queue_status_type;

   // Kind of an opener, KIND_NONE otherwise
   function automatic logic [1:0] opener_kind(input logic [7:0] ch);
      logic [1:0] k;
      unique case (ch)
         CH_OPEN_ROUND:  k = KIND_ROUND;
         CH_OPEN_CURLY:  k = KIND_CURLY;
         CH_OPEN_SQUARE: k = KIND_SQUARE;
         default:        k = KIND_NONE;
      endcase
      return k;
   endfunction

   // Kind of a closer, KIND_NONE otherwise
   function automatic logic [1:0] closer_kind(input logic [7:0] ch);
      logic [1:0] k;
      unique case (ch)
         CH_CLOSE_ROUND:  k = KIND_ROUND;
         CH_CLOSE_CURLY:  k = KIND_CURLY;
         CH_CLOSE_SQUARE: k = KIND_SQUARE;
         default:         k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

@@ design/bbc_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one expression byte and its last flag.
// ----------------------------------------------------------------------------
interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface

@@ design/bbc_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one verdict per expression.
// ----------------------------------------------------------------------------
interface bbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [6:0] depth_left;

   modport source (output valid, output status, output depth_left, input ready);
   modport sink   (input valid, input status, input depth_left, output ready);
endinterface

@@ design/bracket_balance_checker_core.sv @@
`timescale 1ns / 1ps
// The last byte passes the queue, then the back end registers its verdict.
// Throughput: 1 byte per cycle while no verdict waits on a blocked response channel;
// one stack push or pop per cycle in the back end; the entry under the top is
// prefetched from the stack RAM each cycle. Reset: synchronous, clears the queue,
// stack depth, kept error and response valid; stack RAM is not cleared and needs none.
// ----------------------------------------------------------------------------
// Bracket balance checker core
// Checks bracket nesting of a byte stream and reports one verdict per
// expression.
// ----------------------------------------------------------------------------
module bracket_balance_checker_core
   import bbc_pkg::*;
#(
   parameter int MAX_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   bbc_req_if.sink   req_chan,
   bbc_rsp_if.source rsp_chan
);

   logic                 q_push;
   logic                 q_pop;
   bbc_item_type         q_in_item;
   bbc_item_type         q_head;
   bbc_queue_status_type q_stat;

   bbc_front u_front (
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (q_push),
      .item     (q_in_item)
   );

   bbc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .pop       (q_pop),
      .head      (q_head),
      .q_stat    (q_stat)
   );

   bbc_back #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_stat   (q_stat),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

`ifndef ASSERT_OFF
   // A balanced verdict leaves nothing open
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_OK)) |-> (rsp_chan.depth_left == 7'd0))
      else $error("balanced verdict with open depth");

   // A left-open verdict has openers remaining
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_OPEN)) |-> (rsp_chan.depth_left != 7'd0))
      else $error("left-open verdict with zero depth");

   // Queue is never both full and empty
   assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue status inconsistent");

   // Back end only takes from a non-empty queue
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");
`endif

endmodule

@@ design/bbc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bbc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accepts request transactions and classifies each byte for the back end.
// ----------------------------------------------------------------------------
module bbc_front
   import bbc_pkg::*;
(
   bbc_req_if.sink              req_chan,
   input  bbc_queue_status_type q_stat,
   output logic                 push,
   output bbc_item_type         item
);

   logic [1:0] open_k;
   logic [1:0] close_k;

   // Accept whenever the queue has room
   assign req_chan.ready = !q_stat.full;
   assign push           = req_chan.valid && !q_stat.full;

   // Classify the byte
   always_comb begin
      open_k        = opener_kind(req_chan.ch);
      close_k       = closer_kind(req_chan.ch);
      item.last     = req_chan.last;
      item.is_open  = (open_k != KIND_NONE);
      item.is_close = (close_k != KIND_NONE);
      item.kind     = (open_k != KIND_NONE) ? open_k : close_k;
   end

endmodule

@@ design/bbc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Item queue
// Two-entry FIFO between front and back end.
// ----------------------------------------------------------------------------
module bbc_queue
   import bbc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  bbc_item_type         push_item,
   input  logic                 pop,
   output bbc_item_type         head,
   output bbc_queue_status_type q_stat
);

   bbc_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == 2'd2);
   assign q_stat.empty = (count_ff == 2'd0);

endmodule

@@ design/bbc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Runs the bracket stack: top of stack in a register, the rest in RAM,
// with the entry below the top prefetched every cycle. Issues verdicts.
// ----------------------------------------------------------------------------
module bbc_back
   import bbc_pkg::*;
#(
   parameter int MAX_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bbc_item_type         head,
   input  bbc_queue_status_type q_stat,
   output logic                 pop,
   bbc_rsp_if.source            rsp_chan
);

   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int DW = $clog2(MAX_DEPTH + 1);
   localparam int CW = (DW > 7) ? DW : 7;

   logic [DW-1:0] depth_ff, depth_in, op_depth;
   logic [2:0]    err_ff, err_in, op_err;
   logic [1:0]    tos_ff, tos_in;
   logic          bypass_ff, bypass_in;
   logic [1:0]    bypass_data_ff;
   logic [1:0]    below;
   logic [1:0]    ram_rdata;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [6:0]    rsp_depth_ff, rsp_depth_in;
   logic [CW-1:0] depth_wide;
   logic          verdict;

   // Take an item unless it needs the output register and that is blocked
   assign pop     = !q_stat.empty && (!head.last || !rsp_valid_ff || rsp_chan.ready);
   assign verdict = pop && head.last;

   // Entry under the top: bypass a write made in the previous cycle
   assign below = bypass_ff ? bypass_data_ff : ram_rdata;

   // Stack operation
   always_comb begin
      op_depth = depth_ff;
      op_err   = err_ff;
      tos_in   = tos_ff;
      wr_en    = 1'b0;
      wr_addr  = AW'(depth_ff - DW'(1));
      if (pop && (err_ff == ST_OK)) begin
         if (head.is_open) begin
            if (depth_ff == DW'(MAX_DEPTH)) begin
               op_err = ST_OVERFLOW;
            end else begin
               wr_en    = (depth_ff != '0);
               tos_in   = head.kind;
               op_depth = depth_ff + DW'(1);
            end
         end else if (head.is_close) begin
            priority if (depth_ff == '0) begin
               op_err = ST_EMPTY;
            end else if (tos_ff != head.kind) begin
               op_err = ST_MISMATCH;
            end else begin
               op_depth = depth_ff - DW'(1);
               tos_in   = below;
            end
         end
      end
   end

   // Clear state after a verdict; prefetch the entry under the new top
   always_comb begin
      depth_in  = verdict ? '0 : op_depth;
      err_in    = verdict ? ST_OK : op_err;
      rd_addr   = AW'(depth_in - DW'(2));
      bypass_in = wr_en;
   end

   // Build the verdict
   always_comb begin
      depth_wide    = CW'(op_depth);
      rsp_depth_in  = (depth_wide > CW'(127)) ? 7'd127 : depth_wide[6:0];
      rsp_status_in = ((op_err == ST_OK) && (op_depth != '0)) ? ST_OPEN : op_err;
      priority if (verdict) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   bbc_ram #(
      .WIDTH (2),
      .DEPTH (MAX_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (tos_ff),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         err_ff       <= ST_OK;
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         err_ff       <= err_in;
         bypass_ff    <= bypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tos_ff         <= tos_in;
      bypass_data_ff <= tos_ff;
      if (verdict) begin
         rsp_status_ff <= rsp_status_in;
         rsp_depth_ff  <= rsp_depth_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.depth_left = rsp_depth_ff;

endmodule

@@ dv/bbc_verdict_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bracket verdict checker
// Watches the byte and verdict channels of the bracket balance checker,
// predicts the verdict of every expression from the accepted bytes and
// compares each accepted verdict, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module bbc_verdict_checker
   import bbc_pkg::*;
#(
   parameter int MAX_DEPTH = 64
) (
   input  logic clock,
   input  logic reset,
   bbc_req_if   req_mon,
   bbc_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   verdicts_pending
);

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] depth_left;
   } verdict_type;

   // Predicted verdicts, oldest first
   verdict_type verdict_q[$];

   // Model of the nesting state
   logic [1:0] kind_stack [MAX_DEPTH];
   int         open_depth;
   logic [2:0] held_err;
   int         fail_tally = 0;

   // Count a failure; print only the first few
   task automatic note_failure(input string what, input int want, input int got);
      fail_tally++;
      if (fail_tally <= 10) begin
         $display("%0t: verdict %s mismatch: expected %0d, got %0d", $realtime, what, want,
                  got);
      end
   endtask

   // Advance the nesting model by one byte; queue a verdict on the last byte
   task automatic predict_byte(input logic [7:0] c, input logic is_last);
      verdict_type v;
      logic [1:0]  open_k;
      logic [1:0]  close_k;
      open_k  = KIND_NONE;
      close_k = KIND_NONE;
      case (c)
         CH_OPEN_ROUND:   open_k  = KIND_ROUND;
         CH_OPEN_CURLY:   open_k  = KIND_CURLY;
         CH_OPEN_SQUARE:  open_k  = KIND_SQUARE;
         CH_CLOSE_ROUND:  close_k = KIND_ROUND;
         CH_CLOSE_CURLY:  close_k = KIND_CURLY;
         CH_CLOSE_SQUARE: close_k = KIND_SQUARE;
         default: ;
      endcase

      // Once an error is held, the stack stays frozen
      if (held_err == ST_OK) begin
         if (open_k != KIND_NONE) begin
            if (open_depth >= MAX_DEPTH) begin
               held_err = ST_OVERFLOW;
            end else begin
               kind_stack[open_depth] = open_k;
               open_depth++;
            end
         end else if (close_k != KIND_NONE) begin
            if (open_depth == 0) begin
               held_err = ST_EMPTY;
            end else if (kind_stack[open_depth-1] != close_k) begin
               held_err = ST_MISMATCH;
            end else begin
               open_depth--;
            end
         end
      end

      if (is_last) begin
         v.status = held_err;
         if (held_err == ST_OK && open_depth != 0) begin
            v.status = ST_OPEN;
         end
         v.depth_left = (open_depth > 127) ? 7'd127 : 7'(open_depth);
         verdict_q.push_back(v);
         open_depth = 0;
         held_err   = ST_OK;
      end
   endtask

   // Compare accepted verdicts, then fold in the accepted byte
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         open_depth = 0;
         held_err   = ST_OK;
         verdict_q.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (verdict_q.size() == 0) begin
               note_failure("unexpected", -1, int'(rsp_mon.status));
            end else begin
               want = verdict_q.pop_front();
               if (rsp_mon.status !== want.status) begin
                  note_failure("status", int'(want.status), int'(rsp_mon.status));
               end
               if (rsp_mon.depth_left !== want.depth_left) begin
                  note_failure("depth_left", int'(want.depth_left),
                               int'(rsp_mon.depth_left));
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            predict_byte(req_mon.ch, req_mon.last);
         end
      end
      mismatch_count   <= fail_tally;
      verdicts_pending <= verdict_q.size();
   end

endmodule

@@ dv/bracket_balance_checker_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bracket balance checker testbench
// Drives byte streams into the checker core: a few hand-picked expressions,
// then random nested expressions (mostly well formed, some corrupted, some
// plain noise, one deep one per phase) under three throttling phases.
// Verdicts are checked by the verdict checker instantiated beside the core.
// ----------------------------------------------------------------------------
module bracket_balance_checker_core_tb;
   import bbc_pkg::*;

   localparam int MAX_DEPTH   = 64;
   localparam int PHASE_BYTES = 300;
   localparam int DRAIN_WAIT  = 10;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   verdicts_pending;
   int   send_idle_pct = 14;
   int   take_idle_pct = 79;
   int   bytes_sent    = 0;

   // Expression under construction
   logic [7:0] expr_q[$];

   bbc_req_if req_chan ();
   bbc_rsp_if rsp_chan ();

   bracket_balance_checker_core #(
      .MAX_DEPTH (MAX_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bbc_verdict_checker #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_verdict_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .mismatch_count   (mismatch_count),
      .verdicts_pending (verdicts_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   initial begin
      #5_000_000;
      $display("[bracket_balance_checker_core] ERROR");
      $finish;
   end

   // Throttle the verdict side
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   function automatic logic [1:0] random_kind();
      return 2'($urandom_range(3, 1));
   endfunction

   function automatic logic [7:0] open_byte(input logic [1:0] k);
      case (k)
         KIND_ROUND: return CH_OPEN_ROUND;
         KIND_CURLY: return CH_OPEN_CURLY;
         default:    return CH_OPEN_SQUARE;
      endcase
   endfunction

   function automatic logic [7:0] close_byte(input logic [1:0] k);
      case (k)
         KIND_ROUND: return CH_CLOSE_ROUND;
         KIND_CURLY: return CH_CLOSE_CURLY;
         default:    return CH_CLOSE_SQUARE;
      endcase
   endfunction

   // Random byte that is not a bracket
   function automatic logic [7:0] filler_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(255));
      end while (b == CH_OPEN_ROUND || b == CH_CLOSE_ROUND || b == CH_OPEN_CURLY ||
                 b == CH_CLOSE_CURLY || b == CH_OPEN_SQUARE || b == CH_CLOSE_SQUARE);
      return b;
   endfunction

   // Present one byte, idling at random first; hold it until accepted
   task automatic send_byte(input logic [7:0] c, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.ch    <= c;
      req_chan.last  <= is_last;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      bytes_sent++;
   endtask

   // Send the built expression, flagging its final byte
   task automatic send_expr();
      foreach (expr_q[i]) begin
         send_byte(expr_q[i], i == expr_q.size() - 1);
      end
      expr_q.delete();
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         expr_q.push_back(s[i]);
      end
      send_expr();
   endtask

   // Drop valid and wait until every predicted verdict has arrived
   task automatic drain_verdicts();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
   endtask

   // Well-formed nesting up to max_nest deep, with filler bytes mixed in
   task automatic build_nested(input int max_nest, input int filler_pct);
      logic [1:0] open_kinds[$];
      logic [1:0] k;
      int         r;
      repeat ($urandom_range(2 * max_nest + 1, 1)) begin
         r = $urandom_range(99);
         if (r < filler_pct) begin
            expr_q.push_back(filler_byte());
         end else if (open_kinds.size() < max_nest &&
                      (open_kinds.size() == 0 || r % 2 == 0)) begin
            k = random_kind();
            open_kinds.push_back(k);
            expr_q.push_back(open_byte(k));
         end else begin
            expr_q.push_back(close_byte(open_kinds.pop_back()));
         end
      end
      while (open_kinds.size() > 0) begin
         expr_q.push_back(close_byte(open_kinds.pop_back()));
      end
   endtask

   // Corrupt a well-formed expression: replace, drop, insert or truncate
   task automatic corrupt_expr();
      int idx;
      idx = $urandom_range(expr_q.size() - 1);
      case ($urandom_range(3))
         0: expr_q[idx] = close_byte(random_kind());
         1: expr_q.delete(idx);
         2: expr_q.insert(idx, close_byte(random_kind()));
         default: expr_q = expr_q[0:idx];
      endcase
      if (expr_q.size() == 0) begin
         expr_q.push_back(close_byte(random_kind()));
      end
   endtask

   // Deep nesting: n_open openers, optionally all closed again
   task automatic build_deep(input int n_open, input bit close_all);
      logic [1:0] open_kinds[$];
      logic [1:0] k;
      repeat (n_open) begin
         k = random_kind();
         open_kinds.push_back(k);
         expr_q.push_back(open_byte(k));
      end
      while (close_all && open_kinds.size() > 0) begin
         expr_q.push_back(close_byte(open_kinds.pop_back()));
      end
   endtask

   initial begin
      int phase_start;
      int r;

      req_chan.valid <= 1'b0;
      req_chan.ch    <= '0;
      req_chan.last  <= 1'b0;
      reset          <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed expressions
      send_text("()");
      send_text("{[()]}");
      send_text(")");
      send_text("(]");
      send_text("[{");
      send_text("))(");
      send_text("(}(");
      send_text("a");
      expr_q.push_back(8'h00);
      expr_q.push_back(8'hFF);
      send_expr();

      // Random expressions, one throttling setting per phase
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 14; take_idle_pct = 79; end
            1: begin send_idle_pct = 79; take_idle_pct = 14; end
            default: begin send_idle_pct = 0; take_idle_pct = 0; end
         endcase
         phase_start = bytes_sent;

         // Open with a deep expression: full stack closed, overflow, left open at full depth
         case (phase)
            0: build_deep(MAX_DEPTH, 1'b1);
            1: begin
               build_deep(MAX_DEPTH + 1, 1'b0);
               expr_q.push_back(CH_CLOSE_ROUND);
            end
            default: begin
               build_deep(MAX_DEPTH, 1'b0);
               expr_q.push_back(filler_byte());
            end
         endcase
         send_expr();

         while (bytes_sent - phase_start < PHASE_BYTES) begin
            r = $urandom_range(99);
            if (r < 70) begin
               build_nested($urandom_range(8, 1), 15);
            end else if (r < 88) begin
               build_nested($urandom_range(6, 1), 10);
               corrupt_expr();
            end else begin
               repeat ($urandom_range(12, 1)) expr_q.push_back(8'($urandom_range(255)));
            end
            send_expr();
         end
         drain_verdicts();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && verdicts_pending == 0) begin
         $display("[bracket_balance_checker_core] OK");
      end else begin
         $display("[bracket_balance_checker_core] ERROR");
      end
      $finish;
   end

endmodule
